// ===== design/dnsq_pkg.sv =====
package dnsq_pkg;

  // Widths of the channel fields.
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned KIND_W  = 4;
  localparam int unsigned QIDX_W  = 16;
  localparam int unsigned LNUM_W  = 7;
  localparam int unsigned FID_W   = 4;
  localparam int unsigned FVAL_W  = 16;
  localparam int unsigned PHASE_W = 3;
  localparam int unsigned HPOS_W  = 4;
  localparam int unsigned LLEFT_W = 6;
  localparam int unsigned TPOS_W  = 2;

  // Parse phases.
  localparam logic [PHASE_W-1:0] PH_HEADER   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_NAME     = 3'd1;
  localparam logic [PHASE_W-1:0] PH_LABEL    = 3'd2;
  localparam logic [PHASE_W-1:0] PH_POINTER  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_TRAILER  = 3'd4;
  localparam logic [PHASE_W-1:0] PH_UNPARSED = 3'd5;

  // Byte kinds.
  localparam logic [KIND_W-1:0] KIND_HEADER   = 4'd0;
  localparam logic [KIND_W-1:0] KIND_LABEL_LEN = 4'd1;
  localparam logic [KIND_W-1:0] KIND_LABEL_CHR = 4'd2;
  localparam logic [KIND_W-1:0] KIND_NAME_END = 4'd3;
  localparam logic [KIND_W-1:0] KIND_PTR_HI   = 4'd4;
  localparam logic [KIND_W-1:0] KIND_PTR_LO   = 4'd5;
  localparam logic [KIND_W-1:0] KIND_TYPE     = 4'd6;
  localparam logic [KIND_W-1:0] KIND_CLASS    = 4'd7;
  localparam logic [KIND_W-1:0] KIND_UNPARSED = 4'd8;

  // Field identifiers.
  localparam logic [FID_W-1:0] FID_NONE    = 4'd0;
  localparam logic [FID_W-1:0] FID_ID      = 4'd1;
  localparam logic [FID_W-1:0] FID_QDCOUNT = 4'd3;
  localparam logic [FID_W-1:0] FID_TYPE    = 4'd7;
  localparam logic [FID_W-1:0] FID_CLASS   = 4'd8;
  localparam logic [FID_W-1:0] FID_PTR     = 4'd9;

  // Message structure constants.
  localparam logic [HPOS_W-1:0] HEADER_LAST  = 4'd11;
  localparam logic [BYTE_W-1:0] POINTER_MASK = 8'hc0;
  localparam logic [LNUM_W-1:0] LABEL_MAX    = 7'd127;

  // One result item.
  typedef struct packed {
    logic [KIND_W-1:0] byte_kind;
    logic [BYTE_W-1:0] echo_byte;
    logic [QIDX_W-1:0] question_index;
    logic [LNUM_W-1:0] label_number;
    logic [FID_W-1:0]  field_id;
    logic [FVAL_W-1:0] field_value;
    logic              malformed;
    logic              last_out;
  } dnsq_res_t;

endpackage

// ===== design/dnsq_in_if.sv =====
interface dnsq_in_if
  import dnsq_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] msg_byte;
  logic              msg_end;

  modport source (output valid, output msg_byte, output msg_end, input ready);
  modport sink (input valid, input msg_byte, input msg_end, output ready);
endinterface

// ===== design/dnsq_out_if.sv =====
interface dnsq_out_if
  import dnsq_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] byte_kind;
  logic [BYTE_W-1:0] echo_byte;
  logic [QIDX_W-1:0] question_index;
  logic [LNUM_W-1:0] label_number;
  logic [FID_W-1:0]  field_id;
  logic [FVAL_W-1:0] field_value;
  logic              malformed;
  logic              last_out;

  modport source (
    output valid, input ready,
    output byte_kind, output echo_byte, output question_index, output label_number,
    output field_id, output field_value, output malformed, output last_out
  );
  modport sink (
    input valid, output ready,
    input byte_kind, input echo_byte, input question_index, input label_number,
    input field_id, input field_value, input malformed, input last_out
  );
endinterface

// ===== design/dns_question_parser.sv =====
// Channel   Direction  Payload
// in_ch     input      msg_byte[7:0], msg_end
// out_ch    output     byte_kind, echo_byte, question_index, label_number,
//                      field_id, field_value, malformed, last_out
//
// Each byte is classified in the cycle it is accepted and its result is
// available in the next cycle; one byte per cycle is sustained while the
// output is not stalled. The rate is set by the single parse-state update,
// done once per transfer. Synchronous active-low reset returns the parser
// to the header phase. A stalled output holds its result; input is taken
// while the output register is empty or is being emptied in the same cycle.
module dns_question_parser
  import dnsq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  dnsq_in_if.sink     in_ch,
  dnsq_out_if.source  out_ch
);

  // Parse state.
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [HPOS_W-1:0]  hdr_pos_r, hdr_pos_nxt;
  logic [LLEFT_W-1:0] lbl_left_r, lbl_left_nxt;
  logic [TPOS_W-1:0]  trl_pos_r, trl_pos_nxt;
  logic [QIDX_W-1:0]  rec_cnt_r, rec_cnt_nxt;
  logic [LNUM_W-1:0]  lbl_cnt_r, lbl_cnt_nxt;
  logic [QIDX_W-1:0]  q_total_r, q_total_nxt;
  logic [BYTE_W-1:0]  hold_r, hold_nxt;

  // Result register.
  logic      out_valid_r;
  dnsq_res_t out_r;
  dnsq_res_t res;

  logic              accept;
  logic [BYTE_W-1:0] b;
  logic [FVAL_W-1:0] word;
  logic [QIDX_W-1:0] rec_inc;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.msg_byte;
  assign word        = {hold_r, b};
  assign rec_inc     = rec_cnt_r + 16'd1;

  // Classify the byte and compute the next parse state.
  always_comb begin
    phase_nxt    = phase_r;
    hdr_pos_nxt  = hdr_pos_r;
    lbl_left_nxt = lbl_left_r;
    trl_pos_nxt  = trl_pos_r;
    rec_cnt_nxt  = rec_cnt_r;
    lbl_cnt_nxt  = lbl_cnt_r;
    q_total_nxt  = q_total_r;
    hold_nxt     = hold_r;

    res                = '0;
    res.byte_kind      = KIND_UNPARSED;
    res.echo_byte      = b;
    res.last_out       = in_ch.msg_end;

    unique case (phase_r)
      PH_HEADER: begin
        res.byte_kind = KIND_HEADER;
        if (!hdr_pos_r[0]) begin
          hold_nxt = b;
        end else begin
          res.field_id    = FID_ID + {1'b0, hdr_pos_r[HPOS_W-1:1]};
          res.field_value = word;
          if (res.field_id == FID_QDCOUNT) begin
            q_total_nxt = word;
          end
        end
        hdr_pos_nxt = hdr_pos_r + 4'd1;
        if (hdr_pos_r == HEADER_LAST) begin
          hdr_pos_nxt = '0;
          rec_cnt_nxt = '0;
          lbl_cnt_nxt = '0;
          phase_nxt   = (q_total_nxt == '0) ? PH_UNPARSED : PH_NAME;
        end
      end
      PH_NAME: begin
        res.question_index = rec_cnt_r;
        res.label_number   = lbl_cnt_r;
        if ((b & POINTER_MASK) != '0) begin
          res.byte_kind = KIND_PTR_HI;
          hold_nxt      = {2'b00, b[5:0]};
          phase_nxt     = PH_POINTER;
        end else if (b == '0) begin
          res.byte_kind = KIND_NAME_END;
          trl_pos_nxt   = '0;
          phase_nxt     = PH_TRAILER;
        end else begin
          res.byte_kind = KIND_LABEL_LEN;
          lbl_left_nxt  = b[LLEFT_W-1:0];
          phase_nxt     = PH_LABEL;
        end
      end
      PH_LABEL: begin
        res.byte_kind      = KIND_LABEL_CHR;
        res.question_index = rec_cnt_r;
        res.label_number   = lbl_cnt_r;
        lbl_left_nxt       = lbl_left_r - 6'd1;
        if (lbl_left_nxt == '0) begin
          if (lbl_cnt_r != LABEL_MAX) begin
            lbl_cnt_nxt = lbl_cnt_r + 7'd1;
          end
          phase_nxt = PH_NAME;
        end
      end
      PH_POINTER: begin
        res.byte_kind      = KIND_PTR_LO;
        res.question_index = rec_cnt_r;
        res.label_number   = lbl_cnt_r;
        res.field_id       = FID_PTR;
        res.field_value    = {2'b00, word[13:0]};
        trl_pos_nxt        = '0;
        phase_nxt          = PH_TRAILER;
      end
      PH_TRAILER: begin
        res.question_index = rec_cnt_r;
        res.byte_kind      = trl_pos_r[1] ? KIND_CLASS : KIND_TYPE;
        if (!trl_pos_r[0]) begin
          hold_nxt = b;
        end else begin
          res.field_id    = trl_pos_r[1] ? FID_CLASS : FID_TYPE;
          res.field_value = word;
        end
        trl_pos_nxt = trl_pos_r + 2'd1;
        if (trl_pos_r == 2'd3) begin
          rec_cnt_nxt = rec_inc;
          lbl_cnt_nxt = '0;
          phase_nxt   = (rec_inc == q_total_r) ? PH_UNPARSED : PH_NAME;
        end
      end
      default: begin
        res.byte_kind = KIND_UNPARSED;
      end
    endcase

    // The final byte flags an unfinished structure and restarts the parser.
    if (in_ch.msg_end) begin
      res.malformed = (phase_nxt != PH_UNPARSED);
      phase_nxt     = PH_HEADER;
      hdr_pos_nxt   = '0;
      lbl_left_nxt  = '0;
      trl_pos_nxt   = '0;
      rec_cnt_nxt   = '0;
      lbl_cnt_nxt   = '0;
      q_total_nxt   = '0;
      hold_nxt      = '0;
    end
  end

  // Parse state registers, advanced on each input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      hdr_pos_r  <= '0;
      lbl_left_r <= '0;
      trl_pos_r  <= '0;
      rec_cnt_r  <= '0;
      lbl_cnt_r  <= '0;
      q_total_r  <= '0;
      hold_r     <= '0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      hdr_pos_r  <= hdr_pos_nxt;
      lbl_left_r <= lbl_left_nxt;
      trl_pos_r  <= trl_pos_nxt;
      rec_cnt_r  <= rec_cnt_nxt;
      lbl_cnt_r  <= lbl_cnt_nxt;
      q_total_r  <= q_total_nxt;
      hold_r     <= hold_nxt;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.byte_kind      = out_r.byte_kind;
  assign out_ch.echo_byte      = out_r.echo_byte;
  assign out_ch.question_index = out_r.question_index;
  assign out_ch.label_number   = out_r.label_number;
  assign out_ch.field_id       = out_r.field_id;
  assign out_ch.field_value    = out_r.field_value;
  assign out_ch.malformed      = out_r.malformed;
  assign out_ch.last_out       = out_r.last_out;

  // The header position never runs past the last header byte.
  a_hdr_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_pos_r <= HEADER_LAST)
    else $error("header position out of range");

  // The final byte of a message returns the parser to the header phase.
  a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.msg_end) |=> (phase_r == PH_HEADER && hdr_pos_r == '0 &&
                                   q_total_r == '0))
    else $error("parser not restarted after final byte");

  // A malformed flag only appears on the final byte of a message.
  a_malformed_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.malformed) |-> out_r.last_out)
    else $error("malformed flag without final byte");

  // Fields are completed only on header, pointer, type and class bytes.
  a_field_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.field_id != FID_NONE) |->
      (out_r.byte_kind == KIND_HEADER || out_r.byte_kind == KIND_PTR_LO ||
       out_r.byte_kind == KIND_TYPE || out_r.byte_kind == KIND_CLASS))
    else $error("field reported on wrong byte kind");

  // Unparsed bytes carry no record position.
  a_unparsed_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.byte_kind == KIND_UNPARSED) |->
      (out_r.question_index == '0 && out_r.label_number == '0))
    else $error("unparsed byte carries a record position");

endmodule

// ===== test/dns_question_parser_tb.sv =====
`timescale 1ns / 1ps

module dns_question_parser_tb;
  import dnsq_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic clk = 1'b0;
  logic rst_n;

  dnsq_in_if  in_ch ();
  dnsq_out_if out_ch ();

  dns_question_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  // Parser state as the testbench tracks it.
  logic [PHASE_W-1:0] exp_phase;
  logic [HPOS_W-1:0]  exp_hdr_pos;
  logic [LLEFT_W-1:0] exp_chars_left;
  logic [TPOS_W-1:0]  exp_trl_pos;
  logic [QIDX_W-1:0]  exp_question;
  logic [LNUM_W-1:0]  exp_labels;
  logic [QIDX_W-1:0]  exp_qdcount;
  logic [BYTE_W-1:0]  exp_high_byte;

  dnsq_res_t         byte_reports_due[$];
  logic [BYTE_W-1:0] msg_bytes[$];

  int unsigned error_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    error_count++;
  endtask

  task automatic clear_parse_state();
    exp_phase      = PH_HEADER;
    exp_hdr_pos    = '0;
    exp_chars_left = '0;
    exp_trl_pos    = '0;
    exp_question   = '0;
    exp_labels     = '0;
    exp_qdcount    = '0;
    exp_high_byte  = '0;
  endtask

  // Classify one message byte and advance the tracked parser state.
  task automatic classify_byte(input logic [BYTE_W-1:0] b, input logic last,
                               output dnsq_res_t r);
    r = '0;
    r.byte_kind = KIND_UNPARSED;
    r.echo_byte = b;
    r.last_out  = last;
    case (exp_phase)
      PH_HEADER: begin
        r.byte_kind = KIND_HEADER;
        if (!exp_hdr_pos[0]) begin
          exp_high_byte = b;
        end else begin
          r.field_id    = FID_ID + FID_W'(exp_hdr_pos[HPOS_W-1:1]);
          r.field_value = {exp_high_byte, b};
          if (r.field_id == FID_QDCOUNT) exp_qdcount = r.field_value;
        end
        if (exp_hdr_pos == HEADER_LAST) begin
          exp_hdr_pos  = '0;
          exp_question = '0;
          exp_labels   = '0;
          exp_phase    = (exp_qdcount == '0) ? PH_UNPARSED : PH_NAME;
        end else begin
          exp_hdr_pos = exp_hdr_pos + 1'b1;
        end
      end
      PH_NAME: begin
        r.question_index = exp_question;
        r.label_number   = exp_labels;
        if ((b & POINTER_MASK) != '0) begin
          r.byte_kind   = KIND_PTR_HI;
          exp_high_byte = {2'b00, b[5:0]};
          exp_phase     = PH_POINTER;
        end else if (b == '0) begin
          r.byte_kind = KIND_NAME_END;
          exp_trl_pos = '0;
          exp_phase   = PH_TRAILER;
        end else begin
          r.byte_kind    = KIND_LABEL_LEN;
          exp_chars_left = b[5:0];
          exp_phase      = PH_LABEL;
        end
      end
      PH_LABEL: begin
        r.byte_kind      = KIND_LABEL_CHR;
        r.question_index = exp_question;
        r.label_number   = exp_labels;
        exp_chars_left   = exp_chars_left - 1'b1;
        if (exp_chars_left == '0) begin
          if (exp_labels < LABEL_MAX) exp_labels = exp_labels + 1'b1;
          exp_phase = PH_NAME;
        end
      end
      PH_POINTER: begin
        r.byte_kind      = KIND_PTR_LO;
        r.question_index = exp_question;
        r.label_number   = exp_labels;
        r.field_id       = FID_PTR;
        r.field_value    = {2'b00, exp_high_byte[5:0], b};
        exp_trl_pos      = '0;
        exp_phase        = PH_TRAILER;
      end
      PH_TRAILER: begin
        r.question_index = exp_question;
        r.byte_kind      = exp_trl_pos[1] ? KIND_CLASS : KIND_TYPE;
        if (!exp_trl_pos[0]) begin
          exp_high_byte = b;
        end else begin
          r.field_id    = exp_trl_pos[1] ? FID_CLASS : FID_TYPE;
          r.field_value = {exp_high_byte, b};
        end
        exp_trl_pos = exp_trl_pos + 1'b1;
        if (exp_trl_pos == '0) begin
          exp_question = exp_question + 1'b1;
          exp_labels   = '0;
          exp_phase    = (exp_question == exp_qdcount) ? PH_UNPARSED : PH_NAME;
        end
      end
      default: r.byte_kind = KIND_UNPARSED;
    endcase
    // The final byte flags an unfinished message and restarts the parser.
    if (last) begin
      r.malformed = (exp_phase != PH_UNPARSED);
      clear_parse_state();
    end
  endtask

  // Offer one byte, wait for its transfer and queue its expected report.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
    dnsq_res_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      in_ch.msg_byte = BYTE_W'($urandom);
      in_ch.msg_end  = 1'($urandom);
      @(negedge clk);
    end
    in_ch.valid    = 1'b1;
    in_ch.msg_byte = b;
    in_ch.msg_end  = last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    classify_byte(b, last, want);
    byte_reports_due.push_back(want);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_message();
    foreach (msg_bytes[i]) send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    msg_bytes.delete();
  endtask

  task automatic push16(input logic [15:0] v);
    msg_bytes.push_back(v[15:8]);
    msg_bytes.push_back(v[7:0]);
  endtask

  task automatic push_header(input logic [15:0] id, input logic [15:0] flags,
                             input logic [15:0] qd, input logic [15:0] an,
                             input logic [15:0] ns, input logic [15:0] ar);
    push16(id);
    push16(flags);
    push16(qd);
    push16(an);
    push16(ns);
    push16(ar);
  endtask

  // One question: labels of random text, then a zero byte or a pointer, then type and class.
  task automatic push_question(input int unsigned labels, input int unsigned max_len,
                               input bit use_pointer);
    int unsigned len;
    repeat (labels) begin
      len = $urandom_range(1, max_len);
      msg_bytes.push_back(BYTE_W'(len));
      repeat (len) msg_bytes.push_back(BYTE_W'($urandom));
    end
    if (use_pointer) begin
      msg_bytes.push_back({2'($urandom_range(1, 3)), 6'($urandom)});
      msg_bytes.push_back(BYTE_W'($urandom));
    end else begin
      msg_bytes.push_back(8'h00);
    end
    push16(16'($urandom));
    push16(16'($urandom));
  endtask

  // Mostly well-formed messages, some cut short, some plain noise.
  task automatic build_random_message();
    int unsigned shape;
    int unsigned qd;
    int unsigned cut;
    shape = $urandom_range(99);
    if (shape < 10) begin
      repeat ($urandom_range(1, 40)) msg_bytes.push_back(BYTE_W'($urandom));
    end else begin
      qd = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 3);
      push_header(16'($urandom), 16'($urandom), 16'(qd), 16'($urandom),
                  16'($urandom), 16'($urandom));
      repeat (qd) begin
        push_question($urandom_range(0, 4), ($urandom_range(7) == 0) ? 63 : 8,
                      $urandom_range(1));
      end
      repeat ($urandom_range(0, 3)) msg_bytes.push_back(BYTE_W'($urandom));
      if (shape < 25) begin
        cut = $urandom_range(1, msg_bytes.size() - 1);
        while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
      end
    end
  endtask

  // Short directed messages: a lone byte, a cut header, a header with no questions.
  task automatic test_short_messages();
    msg_bytes.push_back(8'hff);
    send_message();
    push16(16'hffff);
    push16(16'h0000);
    msg_bytes.push_back(8'h80);
    send_message();
    push_header(16'hffff, 16'h0000, 16'h0000, 16'hffff, 16'h0000, 16'h8001);
    msg_bytes.push_back(8'h00);
    msg_bytes.push_back(8'hff);
    send_message();
  endtask

  // A name long enough for the label count to saturate, ended by a pointer.
  task automatic test_label_saturation();
    push_header(16'($urandom), 16'($urandom), 16'h0001, 16'h0000, 16'h0000, 16'h0000);
    push_question(129, 1, 1'b1);
    msg_bytes.push_back(BYTE_W'($urandom));
    send_message();
  endtask

  task automatic test_random_messages(input int unsigned count);
    int unsigned target;
    target = bytes_sent + count;
    while (bytes_sent < target) begin
      build_random_message();
      send_message();
    end
  endtask

  // Receiver stalls at random, one decision per cycle.
  always @(negedge clk) begin
    if (rst_n) out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each result transfer with the oldest expected report.
  always @(posedge clk) begin
    dnsq_res_t got;
    dnsq_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.byte_kind      = out_ch.byte_kind;
      got.echo_byte      = out_ch.echo_byte;
      got.question_index = out_ch.question_index;
      got.label_number   = out_ch.label_number;
      got.field_id       = out_ch.field_id;
      got.field_value    = out_ch.field_value;
      got.malformed      = out_ch.malformed;
      got.last_out       = out_ch.last_out;
      if (byte_reports_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result, byte %02h", got.echo_byte));
      end else begin
        want = byte_reports_due.pop_front();
        if (got.byte_kind !== want.byte_kind)
          report_mismatch($sformatf("byte_kind %0d, want %0d", got.byte_kind, want.byte_kind));
        if (got.echo_byte !== want.echo_byte)
          report_mismatch($sformatf("echo_byte %02h, want %02h", got.echo_byte, want.echo_byte));
        if (got.question_index !== want.question_index)
          report_mismatch($sformatf("question_index %0d, want %0d",
                                    got.question_index, want.question_index));
        if (got.label_number !== want.label_number)
          report_mismatch($sformatf("label_number %0d, want %0d",
                                    got.label_number, want.label_number));
        if (got.field_id !== want.field_id)
          report_mismatch($sformatf("field_id %0d, want %0d", got.field_id, want.field_id));
        if (got.field_value !== want.field_value)
          report_mismatch($sformatf("field_value %04h, want %04h",
                                    got.field_value, want.field_value));
        if (got.malformed !== want.malformed)
          report_mismatch($sformatf("malformed %b, want %b", got.malformed, want.malformed));
        if (got.last_out !== want.last_out)
          report_mismatch($sformatf("last_out %b, want %b", got.last_out, want.last_out));
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.msg_byte = '0;
    in_ch.msg_end  = 1'b0;
    out_ch.ready   = 1'b0;
    clear_parse_state();
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    test_short_messages();
    test_random_messages(120);

    send_idle_pct = 51;
    test_random_messages(120);

    send_idle_pct  = 0;
    recv_stall_pct = 51;
    test_random_messages(120);

    send_idle_pct  = 14;
    recv_stall_pct = 14;
    test_label_saturation();
    test_random_messages(120);

    in_ch.valid = 1'b0;
    while (byte_reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (byte_reports_due.size() != 0) report_mismatch("expected results left over");

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/dnsq_pkg.sv
design/dnsq_in_if.sv
design/dnsq_out_if.sv
design/dns_question_parser.sv
test/dns_question_parser_tb.sv
